/* hdl/sgr_pkg.sv */
// shared types, constants and colour palette functions for the sgr attribute decoder
package sgr_pkg;

  localparam int unsigned ParamW = 16;
  localparam int unsigned QDepth = 5;
  localparam int unsigned CntW   = 3;
  localparam int unsigned RgbW   = 24;
  localparam int unsigned StyleW = 9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } state_e;

  typedef enum logic [CntW-1:0] {
    CONSUME_ONE   = 3'd1,
    CONSUME_THREE = 3'd3,
    CONSUME_FIVE  = 3'd5
  } consume_e;

  typedef struct packed {
    logic [StyleW-1:0] style;
    logic [1:0]        underline;
    logic [1:0]        blink;
    logic              fg_dflt;
    logic [RgbW-1:0]   fg;
    logic              bg_dflt;
    logic [RgbW-1:0]   bg;
  } attr_t;

  typedef struct packed {
    logic     stop;
    consume_e consume;
  } step_t;

  localparam attr_t AttrReset = '{
    style:     '0,
    underline: 2'd0,
    blink:     2'd0,
    fg_dflt:   1'b1,
    fg:        '0,
    bg_dflt:   1'b1,
    bg:        '0
  };

  localparam logic [RgbW-1:0] BasePalette [16] = '{
    24'h000000, 24'hCD0000, 24'h00CD00, 24'hCDCD00,
    24'h0000EE, 24'hCD00CD, 24'h00CDCD, 24'hE5E5E5,
    24'h7F7F7F, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
    24'h5C5CFF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
  };

  function automatic logic [7:0] cube_level(logic [2:0] v);
    cube_level = (v == 3'd0) ? 8'd0 : 8'(8'd55 + 8'(v) * 8'd40);
  endfunction

  // xterm 256 palette: base colours, 6x6x6 cube, grey ramp
  function automatic logic [RgbW-1:0] palette_rgb(logic [7:0] idx);
    logic [7:0] n;
    logic [7:0] rem;
    logic [7:0] grey;
    logic [2:0] r6;
    logic [2:0] g6;
    logic [2:0] b6;
    n    = 8'(idx - 8'd16);
    r6   = '0;
    g6   = '0;
    for (int k = 1; k < 6; k++) begin
      if (n >= 8'(36 * k)) r6 = 3'(k);
    end
    rem  = 8'(n - 8'(r6) * 8'd36);
    for (int k = 1; k < 6; k++) begin
      if (rem >= 8'(6 * k)) g6 = 3'(k);
    end
    b6   = 3'(rem - 8'(g6) * 8'd6);
    grey = 8'(8'd8 + 8'(idx - 8'd232) * 8'd10);
    if (idx < 8'd16) begin
      palette_rgb = BasePalette[idx[3:0]];
    end else if (idx < 8'd232) begin
      palette_rgb = {cube_level(r6), cube_level(g6), cube_level(b6)};
    end else begin
      palette_rgb = {grey, grey, grey};
    end
  endfunction

endpackage

/* hdl/sgr_step.sv */
// one decode step: applies the code at the head of the parameter queue
module sgr_step import sgr_pkg::*; (
  input  attr_t             attr_i,
  input  logic [ParamW-1:0] head_i [QDepth],
  input  logic [CntW-1:0]   count_i,
  input  logic              last_i,
  output attr_t             attr_o,
  output step_t             step_o
);

  localparam logic [ParamW-1:0] SgrReset      = 16'd0;
  localparam logic [ParamW-1:0] SgrBold       = 16'd1;
  localparam logic [ParamW-1:0] SgrFaint      = 16'd2;
  localparam logic [ParamW-1:0] SgrItalic     = 16'd3;
  localparam logic [ParamW-1:0] SgrUnderline  = 16'd4;
  localparam logic [ParamW-1:0] SgrSlowBlink  = 16'd5;
  localparam logic [ParamW-1:0] SgrFastBlink  = 16'd6;
  localparam logic [ParamW-1:0] SgrInverse    = 16'd7;
  localparam logic [ParamW-1:0] SgrConceal    = 16'd8;
  localparam logic [ParamW-1:0] SgrStrike     = 16'd9;
  localparam logic [ParamW-1:0] SgrDoubleUl   = 16'd21;
  localparam logic [ParamW-1:0] SgrNoUl       = 16'd24;
  localparam logic [ParamW-1:0] SgrNoBlink    = 16'd25;
  localparam logic [ParamW-1:0] SgrNoInverse  = 16'd27;
  localparam logic [ParamW-1:0] SgrNoConceal  = 16'd28;
  localparam logic [ParamW-1:0] SgrNoStrike   = 16'd29;
  localparam logic [ParamW-1:0] SgrFgExt      = 16'd38;
  localparam logic [ParamW-1:0] SgrFgDefault  = 16'd39;
  localparam logic [ParamW-1:0] SgrBgExt      = 16'd48;
  localparam logic [ParamW-1:0] SgrBgDefault  = 16'd49;
  localparam logic [ParamW-1:0] SgrFramed     = 16'd51;
  localparam logic [ParamW-1:0] SgrEncircled  = 16'd52;
  localparam logic [ParamW-1:0] SgrOverline   = 16'd53;
  localparam logic [ParamW-1:0] SgrNoFrame    = 16'd54;
  localparam logic [ParamW-1:0] SgrNoOverline = 16'd55;
  localparam logic [ParamW-1:0] SgrFgBase     = 16'd30;
  localparam logic [ParamW-1:0] SgrBgBase     = 16'd40;
  localparam logic [ParamW-1:0] SgrFgBright   = 16'd90;
  localparam logic [ParamW-1:0] SgrBgBright   = 16'd100;
  localparam logic [ParamW-1:0] ModeRgb       = 16'd2;
  localparam logic [ParamW-1:0] ModePalette   = 16'd5;

  logic [ParamW-1:0] code;
  logic              is_fg;
  logic [RgbW-1:0]   ext_rgb;
  logic              ext_set;

  assign code  = head_i[0];
  assign is_fg = (code == SgrFgExt);

  always_comb begin
    attr_o         = attr_i;
    step_o.stop    = 1'b0;
    step_o.consume = CONSUME_ONE;
    ext_set        = 1'b0;
    ext_rgb        = palette_rgb(head_i[2][7:0]);
    if (code != SgrFgExt && code != SgrBgExt) begin
      case (code)
        SgrReset:      attr_o = AttrReset;
        SgrBold:       attr_o.style[0] = 1'b1;
        SgrFaint:      attr_o.style[1] = 1'b1;
        SgrItalic:     attr_o.style[2] = 1'b1;
        SgrUnderline:  attr_o.underline = 2'd1;
        SgrDoubleUl:   attr_o.underline = 2'd2;
        SgrNoUl:       attr_o.underline = 2'd0;
        SgrSlowBlink:  attr_o.blink = 2'd1;
        SgrFastBlink:  attr_o.blink = 2'd2;
        SgrNoBlink:    attr_o.blink = 2'd0;
        SgrInverse:    attr_o.style[3] = 1'b1;
        SgrNoInverse:  attr_o.style[3] = 1'b0;
        SgrStrike:     attr_o.style[4] = 1'b1;
        SgrNoStrike:   attr_o.style[4] = 1'b0;
        SgrConceal:    attr_o.style[5] = 1'b1;
        SgrNoConceal:  attr_o.style[5] = 1'b0;
        SgrFgDefault: begin
          attr_o.fg_dflt = 1'b1;
          attr_o.fg      = '0;
        end
        SgrBgDefault: begin
          attr_o.bg_dflt = 1'b1;
          attr_o.bg      = '0;
        end
        SgrFramed:     attr_o.style[6] = 1'b1;
        SgrEncircled:  attr_o.style[7] = 1'b1;
        SgrOverline:   attr_o.style[8] = 1'b1;
        SgrNoFrame:    attr_o.style[7:6] = 2'b00;
        SgrNoOverline: attr_o.style[8] = 1'b0;
        default: begin
          if (code >= SgrFgBase && code <= SgrFgBase + 16'd7) begin
            attr_o.fg_dflt = 1'b0;
            attr_o.fg      = BasePalette[4'(code - SgrFgBase)];
          end else if (code >= SgrBgBase && code <= SgrBgBase + 16'd7) begin
            attr_o.bg_dflt = 1'b0;
            attr_o.bg      = BasePalette[4'(code - SgrBgBase)];
          end else if (code >= SgrFgBright && code <= SgrFgBright + 16'd7) begin
            attr_o.fg_dflt = 1'b0;
            attr_o.fg      = BasePalette[4'(code - SgrFgBright + 16'd8)];
          end else if (code >= SgrBgBright && code <= SgrBgBright + 16'd7) begin
            attr_o.bg_dflt = 1'b0;
            attr_o.bg      = BasePalette[4'(code - SgrBgBright + 16'd8)];
          end
        end
      endcase
    end else if (count_i < 3'd2) begin
      step_o.stop = !last_i;
    end else if (head_i[1] == ModePalette) begin
      if (count_i >= 3'd3) begin
        ext_set        = 1'b1;
        step_o.consume = CONSUME_THREE;
      end else begin
        step_o.stop = !last_i;
      end
    end else if (head_i[1] == ModeRgb) begin
      if (count_i >= 3'd5) begin
        ext_set        = 1'b1;
        ext_rgb        = {head_i[2][7:0], head_i[3][7:0], head_i[4][7:0]};
        step_o.consume = CONSUME_FIVE;
      end else begin
        step_o.stop = !last_i;
      end
    end
    // a bad mode or a cut-short sequence falls through: drop the 38 or 48 only
    if (ext_set) begin
      if (is_fg) begin
        attr_o.fg_dflt = 1'b0;
        attr_o.fg      = ext_rgb;
      end else begin
        attr_o.bg_dflt = 1'b0;
        attr_o.bg      = ext_rgb;
      end
    end
  end

endmodule

/* hdl/sgr_attribute_decoder.sv */
// sgr attribute decoder: takes sgr parameters one per item, emits the attribute register
// an item is taken in ST_IDLE, then 1 to 4 decode steps run in the shared step unit,
// one per queued code; for the last item the result follows in the cycle after the last step
// a new item is taken only in ST_IDLE, once the steps of the previous one are done; replay of
// held extended-colour parameters adds up to 3 steps
// reset: attributes return to their defaults and nothing is held; no clearing pass
module sgr_attribute_decoder import sgr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ParamW-1:0]   param_value_i,
  input  logic                last_param_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [StyleW-1:0]   style_flags_o,
  output logic [1:0]          underline_style_o,
  output logic [1:0]          blink_mode_o,
  output logic                fg_is_default_o,
  output logic [RgbW-1:0]     fg_rgb_o,
  output logic                bg_is_default_o,
  output logic [RgbW-1:0]     bg_rgb_o
);

  state_e            state_q, state_d;
  attr_t             attr_q, attr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              last_q, last_d;
  logic [ParamW-1:0] queue_q [QDepth];
  logic [ParamW-1:0] queue_d [QDepth];
  attr_t             step_attr;
  step_t             step;
  logic              in_fire;
  logic [CntW-1:0]   cnt_left;

  assign in_fire  = in_valid_i && in_ready_o;
  assign cnt_left = cnt_q - step.consume;

  sgr_step u_step (
    .attr_i  (attr_q),
    .head_i  (queue_q),
    .count_i (cnt_q),
    .last_i  (last_q),
    .attr_o  (step_attr),
    .step_o  (step)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_RUN;
      ST_RUN: begin
        if (step.stop || cnt_left == '0) state_d = last_q ? ST_OUT : ST_IDLE;
      end
      ST_OUT:  if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    attr_d  = attr_q;
    cnt_d   = cnt_q;
    last_d  = last_q;
    queue_d = queue_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          queue_d[cnt_q] = param_value_i;
          cnt_d          = cnt_q + 3'd1;
          last_d         = last_param_i;
        end
      end
      ST_RUN: begin
        if (step.stop) begin
          // leftover extended-colour parameters stay queued for the next item
          cnt_d = cnt_q;
        end else begin
          attr_d = step_attr;
          cnt_d  = cnt_left;
          for (int i = 0; i < QDepth; i++) begin
            case (step.consume)
              CONSUME_ONE:   if (i + 1 < QDepth) queue_d[i] = queue_q[i+1];
              CONSUME_THREE: if (i + 3 < QDepth) queue_d[i] = queue_q[i+3];
              CONSUME_FIVE:  queue_d[i] = queue_q[i];
              default:       queue_d[i] = queue_q[i];
            endcase
          end
        end
        if ((step.stop || cnt_left == '0) && last_q) cnt_d = '0;
      end
      ST_OUT:  ;
      default: ;
    endcase
  end

  assign in_ready_o        = (state_q == ST_IDLE);
  assign out_valid_o       = (state_q == ST_OUT);
  assign style_flags_o     = attr_q.style;
  assign underline_style_o = attr_q.underline;
  assign blink_mode_o      = attr_q.blink;
  assign fg_is_default_o   = attr_q.fg_dflt;
  assign fg_rgb_o          = attr_q.fg;
  assign bg_is_default_o   = attr_q.bg_dflt;
  assign bg_rgb_o          = attr_q.bg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      attr_q  <= AttrReset;
      cnt_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      attr_q  <= attr_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    queue_q <= queue_d;
  end

endmodule

/* hdl/sgr_checker.sv */
// port-level assertions for the sgr attribute decoder, with the bind that attaches them
module sgr_checker import sgr_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [StyleW-1:0] style_flags_o,
  input logic [1:0]        underline_style_o,
  input logic [1:0]        blink_mode_o,
  input logic              fg_is_default_o,
  input logic [RgbW-1:0]   fg_rgb_o,
  input logic              bg_is_default_o,
  input logic [RgbW-1:0]   bg_rgb_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(style_flags_o) &&
      $stable(fg_rgb_o) && $stable(bg_rgb_o) && $stable(underline_style_o))
    else $error("result changed while stalled");

  // no new item while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while result pending");

  // an accepted item leaves the block busy, with no result, in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o && !out_valid_o)
    else $error("block idle straight after accepting an item");

  // a default colour always reads as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!fg_is_default_o || fg_rgb_o == '0) &&
      (!bg_is_default_o || bg_rgb_o == '0))
    else $error("default colour with nonzero rgb");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> underline_style_o != 2'd3 && blink_mode_o != 2'd3)
    else $error("illegal underline or blink code");

endmodule

bind sgr_attribute_decoder sgr_checker u_sgr_checker (.*);

/* bench/sgr_tb_pkg.sv */
// sgr parameter codes and extended colour modes shared by the bench
package sgr_tb_pkg;

  typedef enum logic [15:0] {
    SGR_RESET        = 16'd0,
    SGR_BOLD         = 16'd1,
    SGR_FAINT        = 16'd2,
    SGR_ITALIC       = 16'd3,
    SGR_UNDERLINE    = 16'd4,
    SGR_BLINK_SLOW   = 16'd5,
    SGR_BLINK_RAPID  = 16'd6,
    SGR_INVERSE      = 16'd7,
    SGR_CONCEAL      = 16'd8,
    SGR_STRIKE       = 16'd9,
    SGR_DOUBLE_UL    = 16'd21,
    SGR_UL_OFF       = 16'd24,
    SGR_BLINK_OFF    = 16'd25,
    SGR_INVERSE_OFF  = 16'd27,
    SGR_CONCEAL_OFF  = 16'd28,
    SGR_STRIKE_OFF   = 16'd29,
    SGR_FG_BASE      = 16'd30,
    SGR_FG_EXT       = 16'd38,
    SGR_FG_DEFAULT   = 16'd39,
    SGR_BG_BASE      = 16'd40,
    SGR_BG_EXT       = 16'd48,
    SGR_BG_DEFAULT   = 16'd49,
    SGR_FRAMED       = 16'd51,
    SGR_ENCIRCLED    = 16'd52,
    SGR_OVERLINE     = 16'd53,
    SGR_FRAME_OFF    = 16'd54,
    SGR_OVERLINE_OFF = 16'd55,
    SGR_FG_BRIGHT    = 16'd90,
    SGR_BG_BRIGHT    = 16'd100
  } sgr_code_e;

  localparam logic [15:0] EXT_MODE_INDEXED = 16'd5;
  localparam logic [15:0] EXT_MODE_DIRECT  = 16'd2;

  // base colours run over eight codes
  localparam logic [15:0] BASE_SPAN = 16'd7;

endpackage

/* bench/sgr_attr_checker.sv */
// checker: predicts the attribute register per sequence and compares each result item
module sgr_attr_checker
  import sgr_pkg::*;
  import sgr_tb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [ParamW-1:0] param_value_i,
  input  logic              last_param_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [StyleW-1:0] style_flags_i,
  input  logic [1:0]        underline_style_i,
  input  logic [1:0]        blink_mode_i,
  input  logic              fg_is_default_i,
  input  logic [RgbW-1:0]   fg_rgb_i,
  input  logic              bg_is_default_i,
  input  logic [RgbW-1:0]   bg_rgb_i,
  output int                err_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HoldMax = 4;

  localparam int BitBold      = 0;
  localparam int BitFaint     = 1;
  localparam int BitItalic    = 2;
  localparam int BitInverse   = 3;
  localparam int BitStrike    = 4;
  localparam int BitConceal   = 5;
  localparam int BitFramed    = 6;
  localparam int BitEncircled = 7;
  localparam int BitOverline  = 8;

  localparam logic [RgbW-1:0] Ansi16 [16] = '{
    24'h000000, 24'hCD0000, 24'h00CD00, 24'hCDCD00,
    24'h0000EE, 24'hCD00CD, 24'h00CDCD, 24'hE5E5E5,
    24'h7F7F7F, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
    24'h5C5CFF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
  };

  attr_t       cur_attr;
  logic [15:0] held_words [HoldMax];
  int          held_cnt;
  attr_t       expected_attrs [$];

  function automatic logic [7:0] cube_step(input int unsigned v);
    return (v == 0) ? 8'd0 : 8'(55 + 40 * v);
  endfunction

  function automatic logic [RgbW-1:0] xterm_colour(input logic [7:0] idx);
    int unsigned n;
    logic [7:0]  g;
    if (idx < 8'd16) begin
      return Ansi16[idx[3:0]];
    end
    if (idx < 8'd232) begin
      n = idx - 16;
      return {cube_step(n / 36), cube_step((n / 6) % 6), cube_step(n % 6)};
    end
    g = 8'(8 + 10 * (idx - 232));
    return {g, g, g};
  endfunction

  task automatic paint(input logic is_fg, input logic [RgbW-1:0] rgb);
    if (is_fg) begin
      cur_attr.fg_dflt = 1'b0;
      cur_attr.fg      = rgb;
    end else begin
      cur_attr.bg_dflt = 1'b0;
      cur_attr.bg      = rgb;
    end
  endtask

  task automatic apply_code(input logic [15:0] c);
    case (c)
      SGR_RESET:        cur_attr = AttrReset;
      SGR_BOLD:         cur_attr.style[BitBold] = 1'b1;
      SGR_FAINT:        cur_attr.style[BitFaint] = 1'b1;
      SGR_ITALIC:       cur_attr.style[BitItalic] = 1'b1;
      SGR_UNDERLINE:    cur_attr.underline = 2'd1;
      SGR_DOUBLE_UL:    cur_attr.underline = 2'd2;
      SGR_UL_OFF:       cur_attr.underline = 2'd0;
      SGR_BLINK_SLOW:   cur_attr.blink = 2'd1;
      SGR_BLINK_RAPID:  cur_attr.blink = 2'd2;
      SGR_BLINK_OFF:    cur_attr.blink = 2'd0;
      SGR_INVERSE:      cur_attr.style[BitInverse] = 1'b1;
      SGR_INVERSE_OFF:  cur_attr.style[BitInverse] = 1'b0;
      SGR_STRIKE:       cur_attr.style[BitStrike] = 1'b1;
      SGR_STRIKE_OFF:   cur_attr.style[BitStrike] = 1'b0;
      SGR_CONCEAL:      cur_attr.style[BitConceal] = 1'b1;
      SGR_CONCEAL_OFF:  cur_attr.style[BitConceal] = 1'b0;
      SGR_FG_DEFAULT: begin
        cur_attr.fg_dflt = 1'b1;
        cur_attr.fg      = '0;
      end
      SGR_BG_DEFAULT: begin
        cur_attr.bg_dflt = 1'b1;
        cur_attr.bg      = '0;
      end
      SGR_FRAMED:       cur_attr.style[BitFramed] = 1'b1;
      SGR_ENCIRCLED:    cur_attr.style[BitEncircled] = 1'b1;
      SGR_OVERLINE:     cur_attr.style[BitOverline] = 1'b1;
      SGR_FRAME_OFF: begin
        cur_attr.style[BitFramed]    = 1'b0;
        cur_attr.style[BitEncircled] = 1'b0;
      end
      SGR_OVERLINE_OFF: cur_attr.style[BitOverline] = 1'b0;
      default: begin
        if (c >= SGR_FG_BASE && c <= SGR_FG_BASE + BASE_SPAN) begin
          paint(1'b1, Ansi16[4'(c - SGR_FG_BASE)]);
        end else if (c >= SGR_BG_BASE && c <= SGR_BG_BASE + BASE_SPAN) begin
          paint(1'b0, Ansi16[4'(c - SGR_BG_BASE)]);
        end else if (c >= SGR_FG_BRIGHT && c <= SGR_FG_BRIGHT + BASE_SPAN) begin
          paint(1'b1, Ansi16[4'(c - SGR_FG_BRIGHT + 8)]);
        end else if (c >= SGR_BG_BRIGHT && c <= SGR_BG_BRIGHT + BASE_SPAN) begin
          paint(1'b0, Ansi16[4'(c - SGR_BG_BRIGHT + 8)]);
        end
      end
    endcase
  endtask

  // held words are replayed in front of the new one, then whatever is left is held again
  task automatic take_param(input logic [15:0] w, input logic is_last);
    logic [15:0] words [HoldMax+1];
    int          len;
    int          pos;
    int          avail;
    logic [15:0] c;
    logic        stalled;
    len = held_cnt;
    for (int i = 0; i < len; i++) begin
      words[i] = held_words[i];
    end
    words[len] = w;
    len++;
    pos     = 0;
    stalled = 1'b0;
    while (!stalled && pos < len) begin
      c     = words[pos];
      avail = len - pos;
      if (c != SGR_FG_EXT && c != SGR_BG_EXT) begin
        apply_code(c);
        pos++;
      end else if (avail < 2) begin
        if (is_last) pos++;
        else stalled = 1'b1;
      end else if (words[pos+1] == EXT_MODE_INDEXED) begin
        if (avail >= 3) begin
          paint(c == SGR_FG_EXT, xterm_colour(words[pos+2][7:0]));
          pos += 3;
        end else if (is_last) begin
          pos++;
        end else begin
          stalled = 1'b1;
        end
      end else if (words[pos+1] == EXT_MODE_DIRECT) begin
        if (avail >= 5) begin
          paint(c == SGR_FG_EXT, {words[pos+2][7:0], words[pos+3][7:0], words[pos+4][7:0]});
          pos += 5;
        end else if (is_last) begin
          pos++;
        end else begin
          stalled = 1'b1;
        end
      end else begin
        // bad mode: drop the 38 or 48 and go on from the mode word
        pos++;
      end
    end
    held_cnt = 0;
    while (pos < len && held_cnt < HoldMax) begin
      held_words[held_cnt] = words[pos];
      held_cnt++;
      pos++;
    end
    if (is_last) begin
      held_cnt = 0;
      expected_attrs.push_back(cur_attr);
    end
  endtask

  task automatic check_result();
    attr_t got;
    attr_t want;
    got.style     = style_flags_i;
    got.underline = underline_style_i;
    got.blink     = blink_mode_i;
    got.fg_dflt   = fg_is_default_i;
    got.fg        = fg_rgb_i;
    got.bg_dflt   = bg_is_default_i;
    got.bg        = bg_rgb_i;
    if (expected_attrs.size() == 0) begin
      err_count_o++;
      if (err_count_o <= 10) begin
        $display("[%0t] result item with nothing expected: style %03h ul %0d blink %0d",
                 $realtime, got.style, got.underline, got.blink);
      end
    end else begin
      want = expected_attrs.pop_front();
      if (got !== want) begin
        err_count_o++;
        if (err_count_o <= 10) begin
          $display("[%0t] attribute mismatch", $realtime);
          $display("  exp: style %03h ul %0d blink %0d fg %0d/%06h bg %0d/%06h",
                   want.style, want.underline, want.blink, want.fg_dflt, want.fg,
                   want.bg_dflt, want.bg);
          $display("  got: style %03h ul %0d blink %0d fg %0d/%06h bg %0d/%06h",
                   got.style, got.underline, got.blink, got.fg_dflt, got.fg,
                   got.bg_dflt, got.bg);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_attr    = AttrReset;
      held_cnt    = 0;
      expected_attrs.delete();
      err_count_o = 0;
      pending_o   = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) take_param(param_value_i, last_param_i);
      pending_o = expected_attrs.size();
    end
  end

endmodule

/* bench/tb_top.sv */
// bench top: drives sgr parameter sequences into the decoder and reports the verdict
module tb_top;
  import sgr_pkg::*;
  import sgr_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemTarget = 1350;
  localparam int CycleLimit = 200000;
  localparam int LongHold   = 300;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [ParamW-1:0] param_value_i;
  logic              last_param_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [StyleW-1:0] style_flags_o;
  logic [1:0]        underline_style_o;
  logic [1:0]        blink_mode_o;
  logic              fg_is_default_o;
  logic [RgbW-1:0]   fg_rgb_o;
  logic              bg_is_default_o;
  logic [RgbW-1:0]   bg_rgb_o;

  int          err_count;
  int          pending;
  int          cycle_cnt = 0;
  int          items_sent = 0;
  logic        no_idle = 1'b0;
  logic [15:0] seq_q [$];

  always #1 clk_i = ~clk_i;

  sgr_attribute_decoder u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .param_value_i,
    .last_param_i,
    .out_valid_o,
    .out_ready_i,
    .style_flags_o,
    .underline_style_o,
    .blink_mode_o,
    .fg_is_default_o,
    .fg_rgb_o,
    .bg_is_default_o,
    .bg_rgb_o
  );

  sgr_attr_checker u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i        (in_ready_o),
    .param_value_i,
    .last_param_i,
    .out_valid_i       (out_valid_o),
    .out_ready_i,
    .style_flags_i     (style_flags_o),
    .underline_style_i (underline_style_o),
    .blink_mode_i      (blink_mode_o),
    .fg_is_default_i   (fg_is_default_o),
    .fg_rgb_i          (fg_rgb_o),
    .bg_is_default_i   (bg_is_default_o),
    .bg_rgb_i          (bg_rgb_o),
    .err_count_o       (err_count),
    .pending_o         (pending)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("sgr_attribute_decoder verification failed");
      $finish;
    end
  end

  task automatic send_param(input logic [15:0] w, input logic is_last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    param_value_i <= w;
    last_param_i  <= is_last;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_seq();
    for (int i = 0; i < seq_q.size(); i++) begin
      send_param(seq_q[i], i == seq_q.size() - 1);
    end
    seq_q.delete();
  endtask

  // colour component, now and then beyond eight bits
  function automatic logic [15:0] rand_component();
    return ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                       : 16'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] rand_ext_code();
    return $urandom_range(0, 1) ? SGR_FG_EXT : SGR_BG_EXT;
  endfunction

  task automatic add_group();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      case ($urandom_range(0, 5))
        0:       seq_q.push_back(16'($urandom_range(0, 29)));
        1:       seq_q.push_back(16'($urandom_range(30, 39)));
        2:       seq_q.push_back(16'($urandom_range(40, 49)));
        3:       seq_q.push_back(16'($urandom_range(50, 56)));
        4:       seq_q.push_back(16'($urandom_range(88, 98)));
        default: seq_q.push_back(16'($urandom_range(99, 108)));
      endcase
    end else if (kind < 85) begin
      seq_q.push_back(rand_ext_code());
      if ($urandom_range(0, 1)) begin
        seq_q.push_back(EXT_MODE_INDEXED);
        seq_q.push_back(rand_component());
      end else begin
        seq_q.push_back(EXT_MODE_DIRECT);
        repeat (3) seq_q.push_back(rand_component());
      end
    end else if (kind < 93) begin
      seq_q.push_back(16'($urandom_range(0, 65535)));
    end else begin
      // extended colour with a mode that is mostly neither indexed nor direct
      seq_q.push_back(rand_ext_code());
      seq_q.push_back(16'($urandom_range(0, 65535)));
    end
  endtask

  // extended colour cut short by the end of the sequence
  task automatic add_cut_ext();
    int n;
    n = $urandom_range(0, 3);
    seq_q.push_back(rand_ext_code());
    if (n == 1) seq_q.push_back(EXT_MODE_INDEXED);
    if (n >= 2) seq_q.push_back(EXT_MODE_DIRECT);
    if (n >= 2) seq_q.push_back(rand_component());
    if (n == 3) seq_q.push_back(rand_component());
  endtask

  // receiver: random stalls per item, one long hold so the block backs up
  initial begin
    int gap;
    int taken;
    out_ready_i = 1'b0;
    taken       = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (taken == 60) gap = LongHold;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(negedge clk_i);
      while (!out_valid_o) @(negedge clk_i);
      @(posedge clk_i);
      taken++;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    param_value_i = '0;
    last_param_i  = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unknown code at the top of the range
    seq_q = '{16'hFFFF};
    send_seq();
    seq_q = '{SGR_BOLD, SGR_ITALIC, SGR_INVERSE, SGR_STRIKE, SGR_CONCEAL, SGR_FRAMED,
              SGR_ENCIRCLED, SGR_OVERLINE, SGR_UNDERLINE, SGR_BLINK_SLOW};
    send_seq();
    // palette index above 255
    seq_q = '{SGR_FG_EXT, EXT_MODE_INDEXED, 16'd300};
    send_seq();
    // direct colour components above 255
    seq_q = '{SGR_BG_EXT, EXT_MODE_DIRECT, 16'd511, 16'd256, 16'hFFFF};
    send_seq();
    // bad mode: the mode word and the rest are handled as plain codes
    seq_q = '{SGR_FG_EXT, SGR_INVERSE, 16'd31};
    send_seq();
    // cut short by the end of the sequence
    seq_q = '{SGR_BG_EXT, EXT_MODE_DIRECT, SGR_BOLD};
    send_seq();
    seq_q = '{SGR_RESET};
    send_seq();

    while (items_sent < ItemTarget) begin
      if ($urandom_range(0, 29) == 0) no_idle = ~no_idle;
      repeat ($urandom_range(1, 4)) add_group();
      if ($urandom_range(0, 9) == 0) add_cut_ext();
      send_seq();
    end
    in_valid_i <= 1'b0;

    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (16) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("sgr_attribute_decoder verification clean");
    end else begin
      $display("sgr_attribute_decoder verification failed");
    end
    $finish;
  end

endmodule
